// File: src/hpa_pkg.sv
// Shared types and codes for the handle pool allocator.
package hpa_pkg;

   // Operation codes carried in the request opcode field.
   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_TRY   = 2'd1;
   localparam logic [1:0] OP_FREE  = 2'd2;

   // Status codes carried in the response status field.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NONE      = 2'd1;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

   // Request payload.
   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] handle;
   } hpa_req_type;

   // Response payload.
   typedef struct packed {
      logic [7:0] handle_out;
      logic [1:0] status;
   } hpa_rsp_type;

   // Controller states.
   typedef enum logic {
      STATE_IDLE,
      STATE_EXEC
   } hpa_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } hpa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_room;
   } hpa_stat_type;

endpackage

// File: src/hpa_ctrl.sv
// Controller state machine that sequences lookup and update of one request.
module hpa_ctrl import hpa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  hpa_stat_type stat,
   output hpa_cmd_type  cmd
);

   hpa_state_type state_ff;
   hpa_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a transfer starts the lookup, the update waits for output room.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (req_valid) begin
               state_in = STATE_EXEC;
            end
         end
         STATE_EXEC: begin
            if (stat.out_room) begin
               state_in = STATE_IDLE;
            end
         end
         default: state_in = STATE_IDLE;
      endcase
   end

   // Outputs: take requests only when idle, commit once the result can be stored.
   always_comb begin
      req_stall   = 1'b1;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         STATE_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         STATE_EXEC: begin
            cmd.commit = stat.out_room;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule

// File: src/hpa_dp.sv
// Datapath: free queue, in-use bitmap, counters and the response register.
module hpa_dp import hpa_pkg::*; #(
   parameter int POOL_SIZE = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  hpa_req_type  req,
   input  hpa_cmd_type  cmd,
   output hpa_stat_type stat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output hpa_rsp_type  rsp
);

   // Sizes derived from the pool size.
   localparam int CW   = $clog2(POOL_SIZE + 1);
   localparam int QAW  = $clog2(POOL_SIZE);
   localparam int MAPD = (POOL_SIZE < 256) ? POOL_SIZE : 256;
   localparam int MAW  = $clog2(MAPD);
   localparam int CMPW = (CW > 9) ? CW : 9;
   localparam logic [CW-1:0]   POOL_FULL = CW'(POOL_SIZE);
   localparam logic [QAW-1:0]  QLAST     = QAW'(POOL_SIZE - 1);
   localparam logic [CMPW-1:0] MAP_LIMIT = CMPW'(MAPD);

   // Memories: the free queue and the in-use bitmap.
   logic [7:0] q_mem [POOL_SIZE];
   logic       map_mem [MAPD];

   // Control registers.
   logic [QAW-1:0] head_ff, head_in;
   logic [QAW-1:0] tail_ff, tail_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  fresh_ff, fresh_in;
   logic           rsp_valid_ff, rsp_valid_in;

   // Payload registers captured with the request transfer.
   logic [1:0]  op_ff;
   logic [7:0]  hin_ff;
   logic [7:0]  q_rd_ff;
   logic        map_rd_ff;
   hpa_rsp_type rsp_ff;

   // Decision signals.
   logic        is_alloc;
   logic        free_avail;
   logic        fresh_avail;
   logic        grant_q;
   logic        grant_f;
   logic        in_use;
   logic        free_ok;
   logic        map_we;
   logic [MAW-1:0] map_wa;
   logic        map_wd;
   hpa_rsp_type result;

   // Lookup: read the queue head and the bitmap entry of the request handle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req.opcode;
         hin_ff    <= req.handle;
         q_rd_ff   <= q_mem[head_ff];
         map_rd_ff <= map_mem[MAW'(req.handle)];
      end
   end

   // Decide the outcome from the looked-up values.
   always_comb begin
      is_alloc    = (op_ff == OP_ALLOC) || (op_ff == OP_TRY);
      free_avail  = (count_ff != '0);
      fresh_avail = (fresh_ff < POOL_FULL);
      grant_q     = is_alloc && free_avail;
      grant_f     = (op_ff == OP_ALLOC) && !free_avail && fresh_avail;
      // Entries at or above the fresh count were never written since reset.
      in_use      = map_rd_ff && (CMPW'(hin_ff) < CMPW'(fresh_ff));
      free_ok     = (op_ff == OP_FREE) && in_use && (count_ff != POOL_FULL);

      result.handle_out = 8'd0;
      result.status     = ST_OK;
      if (grant_q) begin
         result.handle_out = q_rd_ff;
      end else if (grant_f) begin
         result.handle_out = 8'(fresh_ff);
      end else if (is_alloc) begin
         result.status = ST_NONE;
      end else if ((op_ff == OP_FREE) && !in_use) begin
         result.status = ST_NOT_ALLOC;
      end
   end

   // Bitmap write: set on a grant, clear on a release.
   always_comb begin
      map_we = 1'b0;
      map_wa = MAW'(hin_ff);
      map_wd = 1'b0;
      if (grant_q) begin
         map_we = 1'b1;
         map_wa = MAW'(q_rd_ff);
         map_wd = 1'b1;
      end else if (grant_f) begin
         map_we = (CMPW'(fresh_ff) < MAP_LIMIT);
         map_wa = MAW'(fresh_ff);
         map_wd = 1'b1;
      end else if (free_ok) begin
         map_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && map_we) begin
         map_mem[map_wa] <= map_wd;
      end
   end

   // Queue append on a successful release.
   always_ff @(posedge clock) begin
      if (cmd.commit && free_ok) begin
         q_mem[tail_ff] <= hin_ff;
      end
   end

   // Next values of pointers, counters and the response valid.
   always_comb begin
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      fresh_in     = fresh_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         if (grant_q) begin
            head_in  = (head_ff == QLAST) ? '0 : head_ff + 1'b1;
            count_in = count_ff - 1'b1;
         end
         if (grant_f) begin
            fresh_in = fresh_ff + 1'b1;
         end
         if (free_ok) begin
            tail_in  = (tail_ff == QLAST) ? '0 : tail_ff + 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         fresh_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= result;
      end
   end

   assign stat.out_room = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp           = rsp_ff;

endmodule

// File: src/handle_pool_allocator_top.sv
// Each request runs a lookup step, which reads the queue and bitmap memories,
// and then an update step, which writes them and loads the response register.
// The update waits while a stalled response holds the output; no new request is
// taken until it is done, but a waiting response does not block the next transfer.
// Reset is synchronous and active high; it clears the pointers and counters, and
// the fresh-handle count marks all bitmap entries unused, so no clearing pass runs.
module handle_pool_allocator_top import hpa_pkg::*; #(
   parameter int POOL_SIZE = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hpa_req_type req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hpa_rsp_type rsp
);

   hpa_cmd_type  cmd;
   hpa_stat_type stat;

   // Sequencing of each request.
   hpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Storage and decision logic.
   hpa_dp #(
      .POOL_SIZE (POOL_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

endmodule

// File: src/hpa_checker.sv
// Port-level checks for the handle pool allocator and their binding.
module hpa_checker import hpa_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input hpa_rsp_type rsp
);

   // A stalled response holds its valid and payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   // After a request transfer the block works on it and takes no other.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while one is in progress");

   // A new response only follows a cycle in which a request was in progress.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without a request in progress");

   // Any failed operation grants no handle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != ST_OK) |-> rsp.handle_out == 8'd0)
      else $error("handle granted with an error status");

endmodule

bind handle_pool_allocator_top hpa_checker u_checker (.*);
